// File: src/elpc_pkg.sv
`timescale 1ns / 1ps
// shared constants, item and result types and solver states
// used by edge_limited_path_connectivity and elpc_solver; depends on nothing
package elpc_pkg;

    localparam int MAX_NODES   = 256;
    localparam int NODE_BITS   = 8;
    localparam int MAX_EDGES   = 1024;
    localparam int EDGE_AW     = 10;
    localparam int MAX_QUERIES = 64;
    localparam int QUERY_AW    = 6;
    localparam int WEIGHT_BITS = 32;
    localparam int ITEM_W      = 2 * NODE_BITS + WEIGHT_BITS;

    localparam logic KIND_EDGE  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef struct packed {
        logic [WEIGHT_BITS-1:0] w;
        logic [NODE_BITS-1:0]   b;
        logic [NODE_BITS-1:0]   a;
    } item_t;

    typedef struct packed {
        logic                last;
        logic                ovf;
        logic                conn;
        logic [QUERY_AW-1:0] qidx;
    } res_t;

    typedef enum logic [3:0] {
        S_IDLE, S_QADDR, S_QCAP, S_EADDR, S_ECAP, S_QEVAL,
        S_PRD, S_PCHK, S_JOIN, S_OUT, S_DONE
    } state_t;

endpackage

// File: src/edge_limited_path_connectivity.sv
`timescale 1ns / 1ps
// Loading takes one item per cycle until the item marked tlast; the block then
// stops taking items and answers the stored queries in arrival order. Each query
// scans every stored edge; for each edge under the limit with valid endpoints it
// walks both endpoints to their roots, every step a read of the single read port
// of the parent memory and then a check, and joins the two roots. Results leave
// through an output register, and a stalled result holds the solver. depends on
// elpc_pkg, elpc_ram, elpc_solver
module edge_limited_path_connectivity import elpc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [8:0]  cfg_data,      // node_count
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,       // node_a, node_b, weight_or_limit
    input  logic [0:0]  s_tuser,       // kind
    input  logic        s_tlast,       // last_item
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,       // query_index, connected, overflow
    output logic        m_tlast        // last_result
);
    logic [8:0] node_count_reg;
    logic [EDGE_AW:0] ecnt_reg;
    logic [QUERY_AW:0] qcnt_reg;
    logic ovf_reg, busy_reg, start_reg, acc, done, res_valid, res_ready;
    logic e_we, q_we, m_tvalid_reg;
    logic [EDGE_AW-1:0] e_raddr;
    logic [QUERY_AW-1:0] q_raddr;
    item_t e_rdata, q_rdata, in_item;
    res_t res, res_reg;

    assign cfg_ready = 1'b1;
    assign s_tready = !busy_reg;
    assign acc = s_tvalid && s_tready;
    assign in_item = s_tdata;
    assign e_we = acc && (s_tuser[0] == KIND_EDGE) && (ecnt_reg < MAX_EDGES);
    assign q_we = acc && (s_tuser[0] == KIND_QUERY) && (qcnt_reg < MAX_QUERIES);

    elpc_ram #(.WIDTH(ITEM_W), .DEPTH(MAX_EDGES)) u_edges (
        .aclk(aclk), .we(e_we), .waddr(ecnt_reg[EDGE_AW-1:0]), .wdata(in_item),
        .raddr(e_raddr), .rdata(e_rdata)
    );
    elpc_ram #(.WIDTH(ITEM_W), .DEPTH(MAX_QUERIES)) u_queries (
        .aclk(aclk), .we(q_we), .waddr(qcnt_reg[QUERY_AW-1:0]), .wdata(in_item),
        .raddr(q_raddr), .rdata(q_rdata)
    );

    elpc_solver u_solver (
        .aclk(aclk), .aresetn(aresetn), .start(start_reg),
        .edge_count(ecnt_reg), .query_count(qcnt_reg), .ovf(ovf_reg),
        .node_count(node_count_reg), .e_raddr(e_raddr), .e_rdata(e_rdata),
        .q_raddr(q_raddr), .q_rdata(q_rdata), .res_valid(res_valid),
        .res_ready(res_ready), .res(res), .done(done)
    );

    assign res_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_count_reg <= 9'd256;
            ecnt_reg <= '0;
            qcnt_reg <= '0;
            ovf_reg <= 1'b0;
            busy_reg <= 1'b0;
            start_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) node_count_reg <= cfg_data;
            start_reg <= acc && s_tlast;
            if (acc && s_tlast) busy_reg <= 1'b1;
            if (e_we) ecnt_reg <= ecnt_reg + 1'b1;
            if (q_we) qcnt_reg <= qcnt_reg + 1'b1;
            if (acc && !e_we && !q_we) ovf_reg <= 1'b1;
            if (done) begin
                busy_reg <= 1'b0;
                ecnt_reg <= '0;
                qcnt_reg <= '0;
                ovf_reg <= 1'b0;
            end
            if (res_ready) m_tvalid_reg <= res_valid;
        end
        if (res_ready && res_valid) res_reg <= res;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata = {res_reg.ovf, res_reg.conn, res_reg.qidx};
    assign m_tlast = res_reg.last;

    a_done_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done |-> busy_reg) else $error("solver finished outside a batch");
    a_res_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> busy_reg) else $error("result outside a batch");
    a_ecnt: assert property (@(posedge aclk) disable iff (!aresetn)
        ecnt_reg <= MAX_EDGES) else $error("edge count past capacity");
endmodule

// File: src/elpc_ram.sv
`timescale 1ns / 1ps
// simple dual-port synchronous ram, one write and one registered read port
// depends on nothing
module elpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: src/elpc_solver.sv
`timescale 1ns / 1ps
// per-query union-find sequencer over the stored edges, owns the parent memory
// depends on elpc_pkg and elpc_ram
module elpc_solver import elpc_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [EDGE_AW:0]     edge_count,
    input  logic [QUERY_AW:0]    query_count,
    input  logic                 ovf,
    input  logic [8:0]           node_count,
    output logic [EDGE_AW-1:0]   e_raddr,
    input  item_t                e_rdata,
    output logic [QUERY_AW-1:0]  q_raddr,
    input  item_t                q_rdata,
    output logic                 res_valid,
    input  logic                 res_ready,
    output res_t                 res,
    output logic                 done
);
    state_t state_reg, state_next;
    logic [QUERY_AW:0]  qi_reg, qi_next;
    logic [EDGE_AW:0]   ei_reg, ei_next;
    item_t q_reg, q_next, e_reg, e_next;
    logic [NODE_BITS-1:0] cur_reg, cur_next, ra_reg, ra_next;
    logic phase_reg, phase_next, mode_reg, mode_next, conn_reg, conn_next;
    logic [MAX_NODES-1:0] valid_reg, valid_next;
    logic [NODE_BITS-1:0] p_rdata, par;
    logic p_we, e_use, q_bad, e_last, q_last;

    elpc_ram #(.WIDTH(NODE_BITS), .DEPTH(MAX_NODES)) u_parent (
        .aclk(aclk), .we(p_we), .waddr(ra_reg), .wdata(cur_reg),
        .raddr(cur_reg), .rdata(p_rdata)
    );

    assign e_raddr = ei_reg[EDGE_AW-1:0];
    assign q_raddr = qi_reg[QUERY_AW-1:0];
    assign par     = valid_reg[cur_reg] ? p_rdata : cur_reg;
    assign e_use   = (e_rdata.w < q_reg.w) && ({1'b0, e_rdata.a} < node_count)
                     && ({1'b0, e_rdata.b} < node_count);
    assign q_bad   = ({1'b0, q_reg.a} >= node_count) || ({1'b0, q_reg.b} >= node_count);
    assign e_last  = (ei_reg + 1'b1) == edge_count;
    assign q_last  = (qi_reg + 1'b1) == query_count;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (start) state_next = (query_count == '0) ? S_DONE : S_QADDR;
            S_QADDR: state_next = S_QCAP;
            S_QCAP:  state_next = (edge_count == '0) ? S_QEVAL : S_EADDR;
            S_EADDR: state_next = S_ECAP;
            S_ECAP: begin
                if (e_use) state_next = S_PRD;
                else state_next = e_last ? S_QEVAL : S_EADDR;
            end
            S_QEVAL: begin
                if (q_reg.a == q_reg.b || q_bad) state_next = S_OUT;
                else state_next = S_PRD;
            end
            S_PRD:   state_next = S_PCHK;
            S_PCHK: begin
                if (par != cur_reg || !phase_reg) state_next = S_PRD;
                else state_next = mode_reg ? S_OUT : S_JOIN;
            end
            S_JOIN:  state_next = e_last ? S_QEVAL : S_EADDR;
            S_OUT:   if (res_ready) state_next = q_last ? S_DONE : S_QADDR;
            S_DONE:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        qi_next = qi_reg;
        ei_next = ei_reg;
        q_next = q_reg;
        e_next = e_reg;
        cur_next = cur_reg;
        ra_next = ra_reg;
        phase_next = phase_reg;
        mode_next = mode_reg;
        conn_next = conn_reg;
        valid_next = valid_reg;
        p_we = 1'b0;
        res_valid = 1'b0;
        done = 1'b0;
        unique case (state_reg)
            S_IDLE: qi_next = '0;
            S_QCAP: begin
                q_next = q_rdata;
                valid_next = '0;
                ei_next = '0;
            end
            S_ECAP: begin
                e_next = e_rdata;
                if (e_use) begin
                    cur_next = e_rdata.a;
                    phase_next = 1'b0;
                    mode_next = 1'b0;
                end else begin
                    ei_next = ei_reg + 1'b1;
                end
            end
            S_QEVAL: begin
                if (q_reg.a == q_reg.b) begin
                    conn_next = 1'b1;
                end else if (q_bad) begin
                    conn_next = 1'b0;
                end else begin
                    cur_next = q_reg.a;
                    phase_next = 1'b0;
                    mode_next = 1'b1;
                end
            end
            S_PCHK: begin
                if (par != cur_reg) begin
                    cur_next = par;
                end else if (!phase_reg) begin
                    ra_next = cur_reg;
                    phase_next = 1'b1;
                    cur_next = mode_reg ? q_reg.b : e_reg.b;
                end else if (mode_reg) begin
                    conn_next = (ra_reg == cur_reg);
                end
            end
            S_JOIN: begin
                if (ra_reg != cur_reg) begin
                    p_we = 1'b1;
                    valid_next[ra_reg] = 1'b1;
                end
                ei_next = ei_reg + 1'b1;
            end
            S_OUT: begin
                res_valid = 1'b1;
                if (res_ready) qi_next = qi_reg + 1'b1;
            end
            S_DONE: done = 1'b1;
            default: ;
        endcase
    end

    assign res = '{last: q_last, ovf: ovf, conn: conn_reg,
                   qidx: qi_reg[QUERY_AW-1:0]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            valid_reg <= '0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
        qi_reg <= qi_next;
        ei_reg <= ei_next;
        q_reg <= q_next;
        e_reg <= e_next;
        cur_reg <= cur_next;
        ra_reg <= ra_next;
        phase_reg <= phase_next;
        mode_reg <= mode_next;
        conn_reg <= conn_next;
    end
endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps
// testbench for edge_limited_path_connectivity: batches of edges and queries go in,
// per-query connectivity answers are predicted in the bench and checked in order
// depends on elpc_pkg and the edge_limited_path_connectivity rtl
module testbench;
    import elpc_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000000;
    localparam int CFG_SETTLE     = 30000;

    logic        aclk;
    logic        aresetn;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [8:0]  cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;   // node_a, node_b, weight_or_limit
    logic [0:0]  s_tuser;   // kind
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // query_index, connected, overflow
    logic        m_tlast;

    item_t edge_list[$];
    item_t query_list[$];
    res_t  answers_due[$];
    int    node_limit = 256;
    bit    batch_overflow = 0;
    int    fail_count = 0;
    int    snd_idle_pct = 0;
    int    rcv_stall_pct = 0;
    int    hold_left = 0;
    int    quiet_cycles = 0;

    edge_limited_path_connectivity uut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    always begin
        aclk = 1'b1; #2;
        aclk = 1'b0; #2;
    end

    function automatic bit path_below(item_t q, int nc);
        int    up [MAX_NODES];
        int    ra;
        int    rb;
        if (q.a == q.b) return 1'b1;
        if (q.a >= nc || q.b >= nc) return 1'b0;
        for (int i = 0; i < MAX_NODES; i++) up[i] = i;
        foreach (edge_list[k]) begin
            if (edge_list[k].w < q.w && edge_list[k].a < nc && edge_list[k].b < nc) begin
                ra = edge_list[k].a;
                rb = edge_list[k].b;
                while (up[ra] != ra) ra = up[ra];
                while (up[rb] != rb) rb = up[rb];
                if (ra != rb) up[ra] = rb;
            end
        end
        ra = q.a;
        rb = q.b;
        while (up[ra] != ra) ra = up[ra];
        while (up[rb] != rb) rb = up[rb];
        return ra == rb;
    endfunction

    task automatic take_item(logic kind, item_t it, logic last);
        int    nc;
        res_t  r;
        if (kind == KIND_EDGE) begin
            if (edge_list.size() < MAX_EDGES) edge_list.insert(edge_list.size(), it);
            else batch_overflow = 1;
        end else begin
            if (query_list.size() < MAX_QUERIES) query_list.insert(query_list.size(), it);
            else batch_overflow = 1;
        end
        if (!last) return;
        nc = (node_limit > MAX_NODES) ? MAX_NODES : node_limit;
        foreach (query_list[i]) begin
            r.qidx = i[QUERY_AW-1:0];
            r.conn = path_below(query_list[i], nc);
            r.ovf  = batch_overflow;
            r.last = (i == query_list.size() - 1);
            answers_due.insert(answers_due.size(), r);
        end
        edge_list.delete();
        query_list.delete();
        batch_overflow = 0;
    endtask

    task automatic send_item(logic kind, logic [7:0] a, logic [7:0] b, logic [31:0] w,
                             logic last);
        item_t it;
        it.a = a;
        it.b = b;
        it.w = w;
        while (snd_idle_pct > 0 && $urandom_range(99) < snd_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tdata  = {w, b, a};
        s_tuser  = kind;
        s_tlast  = last;
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        take_item(kind, it, last);
        @(negedge aclk);
        s_tvalid = 1'b0;
    endtask

    task automatic write_node_count(logic [8:0] v);
        s_tvalid = 1'b0;
        wait (answers_due.size() == 0);
        repeat (CFG_SETTLE) @(posedge aclk);
        @(negedge aclk);
        cfg_data  = v;
        cfg_valid = 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        node_limit = v;
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic random_batch(int n, int span);
        logic       kind;
        logic [7:0] a;
        logic [7:0] b;
        logic [31:0] w;
        for (int i = 0; i < n; i++) begin
            kind = ($urandom_range(99) < 40) ? KIND_QUERY : KIND_EDGE;
            a = ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(span - 1));
            b = ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(span - 1));
            w = ($urandom_range(7) == 0) ? $urandom : 32'($urandom_range(20));
            send_item(kind, a, b, w, i == n - 1);
        end
    endtask

    task automatic test_directed();
        send_item(KIND_EDGE, 8'd0, 8'd255, 32'd0, 1'b0);
        send_item(KIND_EDGE, 8'd255, 8'd1, 32'hFFFF_FFFF, 1'b0);
        send_item(KIND_EDGE, 8'd1, 8'd2, 32'd5, 1'b0);
        send_item(KIND_QUERY, 8'd0, 8'd255, 32'd0, 1'b0);
        send_item(KIND_QUERY, 8'd0, 8'd255, 32'd1, 1'b0);
        send_item(KIND_QUERY, 8'd0, 8'd2, 32'hFFFF_FFFF, 1'b0);
        send_item(KIND_QUERY, 8'd0, 8'd2, 32'd6, 1'b0);
        send_item(KIND_QUERY, 8'd7, 8'd7, 32'd0, 1'b0);
        send_item(KIND_QUERY, 8'd255, 8'd2, 32'hFFFF_FFFF, 1'b0);
        send_item(KIND_EDGE, 8'd3, 8'd4, 32'd1, 1'b1);
        // edges only, no answers
        send_item(KIND_EDGE, 8'd3, 8'd4, 32'd1, 1'b0);
        send_item(KIND_EDGE, 8'd5, 8'd6, 32'd2, 1'b1);
        // single query, last on a query
        send_item(KIND_QUERY, 8'd3, 8'd4, 32'd2, 1'b1);
    endtask

    task automatic test_node_count();
        logic [8:0] settings [5] = '{9'd1, 9'd0, 9'd511, 9'd300, 9'd12};
        foreach (settings[i]) begin
            write_node_count(settings[i]);
            send_item(KIND_EDGE, 8'd0, 8'd1, 32'd1, 1'b0);
            send_item(KIND_QUERY, 8'd5, 8'd5, 32'd0, 1'b0);
            send_item(KIND_QUERY, 8'd0, 8'd1, 32'd2, 1'b0);
            random_batch(15, 16);
        end
    endtask

    task automatic test_overflow();
        for (int i = 0; i < MAX_EDGES + 6; i++)
            send_item(KIND_EDGE, 8'($urandom_range(15)), 8'($urandom_range(15)),
                      32'($urandom_range(50)), 1'b0);
        send_item(KIND_QUERY, 8'd0, 8'd9, 32'd40, 1'b0);
        send_item(KIND_QUERY, 8'd3, 8'd4, 32'd10, 1'b1);
        for (int i = 0; i < MAX_QUERIES + 5; i++)
            send_item(KIND_QUERY, 8'($urandom_range(11)), 8'($urandom_range(11)),
                      32'($urandom_range(12)), 1'b0);
        random_batch(6, 12);
        random_batch(10, 12);
    endtask

    task automatic test_random();
        int modes_snd [4] = '{0, 58, 0, 32};
        int modes_rcv [4] = '{0, 0, 58, 32};
        int sent;
        int n;
        for (int m = 0; m < 4; m++) begin
            snd_idle_pct  = modes_snd[m];
            rcv_stall_pct = modes_rcv[m];
            sent = 0;
            while (sent < 100) begin
                n = $urandom_range(30, 3);
                random_batch(n, $urandom_range(12, 3));
                sent += n;
            end
        end
        snd_idle_pct  = 0;
        rcv_stall_pct = 0;
    endtask

    task automatic test_backpressure();
        hold_left = 3000;
        for (int k = 0; k < 4; k++) begin
            for (int i = 0; i < 40; i++)
                send_item(KIND_QUERY, 8'($urandom_range(7)), 8'($urandom_range(7)),
                          32'($urandom_range(9)), 1'b0);
            random_batch(10, 8);
        end
    endtask

    always @(negedge aclk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rcv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (answers_due.size() == 0) begin
                $error("unexpected result item %h last %b", m_tdata, m_tlast);
                fail_count++;
            end else begin
                want = answers_due.pop_front();
                if (m_tdata[5:0] != want.qidx) begin
                    $error("query_index expected %0d actual %0d", want.qidx, m_tdata[5:0]);
                    fail_count++;
                end
                if (m_tdata[6] != want.conn) begin
                    $error("connected expected %0d actual %0d", want.conn, m_tdata[6]);
                    fail_count++;
                end
                if (m_tdata[7] != want.ovf) begin
                    $error("overflow expected %0d actual %0d", want.ovf, m_tdata[7]);
                    fail_count++;
                end
                if (m_tlast != want.last) begin
                    $error("last_result expected %0d actual %0d", want.last, m_tlast);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[edge_limited_path_connectivity] ERROR");
            $finish;
        end
    end

    initial begin
        aresetn   = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        s_tlast   = 1'b0;
        m_tready  = 1'b0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        test_directed();
        test_node_count();
        write_node_count(9'd256);
        test_overflow();
        test_random();
        test_backpressure();
        wait (answers_due.size() == 0);
        repeat (200) @(posedge aclk);
        if (fail_count == 0)
            $display("[edge_limited_path_connectivity] OK");
        else
            $display("[edge_limited_path_connectivity] ERROR");
        $finish;
    end

endmodule

// File: files.f
src/elpc_pkg.sv
src/elpc_ram.sv
src/elpc_solver.sv
src/edge_limited_path_connectivity.sv
bench/testbench.sv
